// ===== rtl/core/stq_pkg.sv =====
// Package for the sorted timer queue: payload structs, codes and shared widths.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

    // Queue capacity; the count field is sized from it
    localparam int QUEUE_DEPTH = 16;

    // Field widths of the transfer payloads
    localparam int TIME_BITS   = 32;
    localparam int ID_BITS     = 8;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_BITS = 2;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        logic                 action;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   task_id;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_status               status;
        logic                  became_head;
        logic                  head_valid;
        logic [TIME_BITS-1:0]  head_deadline;
        logic [ID_BITS-1:0]    head_task;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out_item;

    // One queue entry as held in a cell
    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   task_id;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/core/stq_cell.sv =====
// One cell of the sorted chain: holds one entry, compares, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module stq_cell (
    input  wire                i_clk,
    input  stq_pkg::t_cell_ctrl i_ctrl,
    input  wire                i_valid,   // this cell holds a live entry
    input  wire                i_found,   // an earlier cell takes the new entry
    input  stq_pkg::t_entry    i_left,    // entry of the cell toward the head
    input  stq_pkg::t_entry    i_right,   // entry of the cell toward the tail
    output logic               o_found,
    output stq_pkg::t_entry    o_entry,   // entry held now, seen by neighbors
    output stq_pkg::t_entry    o_next     // value this cell holds after the edge
);

    stq_pkg::t_entry                r_entry;
    stq_pkg::t_entry                n_entry;
    logic [stq_pkg::TIME_BITS-1:0]  diff;
    logic                           not_earlier;
    logic                           take;

    // Wrap-aware test: held deadline is equal to or later than the new one
    assign diff        = r_entry.deadline - i_ctrl.new_entry.deadline;
    assign not_earlier = ~diff[stq_pkg::TIME_BITS-1];

    // First live entry not earlier, or the first free cell, takes the new entry
    assign take    = ~i_found & (~i_valid | not_earlier);
    assign o_found = i_found | take;

    // Next entry: shift toward tail behind the insert point, toward head on remove
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (i_found) begin
                n_entry = i_left;
            end else if (take) begin
                n_entry = i_ctrl.new_entry;
            end
        end else if (i_ctrl.remove) begin
            n_entry = i_right;
        end
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: chain of entry cells, count and result register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (action, deadline, task_id)
//  out     | output    | o_out_valid / i_out_ready | o_out (status, head, count)
//
// One item per cycle: every cell compares and shifts in the cycle of the transfer,
// and the result lands in the output register on the same edge.
// The insert point is found by a one-bit found chain running through the cells.
// Reset (synchronous, active low) empties the queue and the output register.
// While a result waits and i_out_ready is low, o_in_ready is low too.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  stq_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output stq_pkg::t_out_item  o_out
);

    localparam int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH;
    localparam int CNT_W       = stq_pkg::COUNT_BITS;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    stq_pkg::t_out_item   r_out;
    stq_pkg::t_out_item   n_out;

    logic                 in_xfer;
    logic                 full;
    logic                 empty;
    stq_pkg::t_cell_ctrl  ctrl;

    logic                 found [QUEUE_DEPTH+1];
    stq_pkg::t_entry      cell_cur [QUEUE_DEPTH];
    stq_pkg::t_entry      cell_next [QUEUE_DEPTH];
    stq_pkg::t_entry      cell_left [QUEUE_DEPTH];
    stq_pkg::t_entry      cell_right [QUEUE_DEPTH];
    logic                 cell_valid [QUEUE_DEPTH];

    // Input transfer: free output slot or one being drained this cycle
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_xfer    = i_in_valid & o_in_ready;
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty      = (r_count == '0);

    // Command to the cells; a full insert or empty remove leaves them alone
    always_comb begin
        ctrl.insert              = in_xfer & (i_in.action == stq_pkg::ACT_INSERT) & ~full;
        ctrl.remove              = in_xfer & (i_in.action == stq_pkg::ACT_REMOVE) & ~empty;
        ctrl.new_entry.deadline  = i_in.deadline;
        ctrl.new_entry.task_id   = i_in.task_id;
    end

    // Cell chain
    assign found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign cell_valid[g] = (r_count > CNT_W'(g));
        if (g == 0) begin : g_head
            assign cell_left[g] = ctrl.new_entry;
        end else begin : g_mid
            assign cell_left[g] = cell_cur[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign cell_right[g] = ctrl.new_entry;
        end else begin : g_body
            assign cell_right[g] = cell_cur[g+1];
        end

        stq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_valid (cell_valid[g]),
            .i_found (found[g]),
            .i_left  (cell_left[g]),
            .i_right (cell_right[g]),
            .o_found (found[g+1]),
            .o_entry (cell_cur[g]),
            .o_next  (cell_next[g])
        );
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result item, built from the state after this transfer
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (in_xfer) begin
            n_out_valid = 1'b1;
            if (i_in.action == stq_pkg::ACT_INSERT) begin
                n_out.status = full ? stq_pkg::ST_FULL : stq_pkg::ST_OK;
            end else begin
                n_out.status = empty ? stq_pkg::ST_EMPTY : stq_pkg::ST_OK;
            end
            n_out.became_head = ctrl.insert & ~cell_valid[0] |
                                ctrl.insert & found[1];
            n_out.head_valid  = (n_count != '0);
            if (n_count != '0) begin
                n_out.head_deadline = cell_next[0].deadline;
                n_out.head_task     = cell_next[0].task_id;
            end else begin
                n_out.head_deadline = '0;
                n_out.head_task     = '0;
            end
            n_out.entry_count = n_count;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
